@@ rtl/core/vhss_pkg.sv @@
// Shared types and start-code constants for the video header split scanner.
package vhss_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        split_found;
    logic [15:0] split_offset;
    logic        compatible;
  } out_item_t;

  typedef enum logic {
    REG_CODEC_MODE = 1'b0,
    REG_CHECK_ONLY = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_H264 = 1'b0,
    MODE_MPEG = 1'b1
  } codec_mode_t;

  localparam logic [31:0] SHIFT_RESET   = 32'hFFFF_FFFF;
  localparam logic [31:0] NAL_TYPE_MASK = 32'hFFFF_FF1F;
  localparam logic [31:0] PREFIX_MASK   = 32'hFFFF_FF00;
  localparam logic [31:0] NAL_SPS       = 32'h0000_0107;
  localparam logic [31:0] NAL_PPS       = 32'h0000_0108;
  localparam logic [31:0] NAL_SLICE     = 32'h0000_0101;
  localparam logic [31:0] NAL_SLICE_DPA = 32'h0000_0102;
  localparam logic [31:0] NAL_IDR       = 32'h0000_0105;
  localparam logic [31:0] START_PREFIX  = 32'h0000_0100;
  localparam logic [31:0] SEQ_HEADER    = 32'h0000_01B3;
  localparam logic [31:0] SEQ_EXTENSION = 32'h0000_01B5;
  localparam logic [31:0] START_END     = 32'h0000_0200;
  localparam logic [31:0] OFS_MAX       = 32'h0000_FFFF;

endpackage

@@ rtl/core/video_header_split_scanner.sv @@
// Start-code scanner that finds where the header part of a video buffer ends.
//
//   channel  | direction | handshake          | payload
//   in_      | input     | in_valid/in_stall  | in_item  (data_byte, last_byte)
//   out_     | output    | out_valid/out_stall| out_item (split_found, offset, compatible)
//   cfg      | APB       | psel/penable       | codec_mode, check_only
//
// One byte per cycle unless the result is stalled: a byte waits in the input register,
// then the shift word compare logic updates the scan state and loads the result register.
// The result register loads together with the scan state, from the input register byte.
// Reset (rst_n, synchronous) clears scan state, configuration and valid flags; the state also
// returns to reset after each last byte. A stalled result holds the compute
// stage; the input register still takes one byte, then stalls the input.
module video_header_split_scanner
  import vhss_pkg::*;
#(
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // configuration
  logic codec_mode_r, check_only_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[2]))
      REG_CODEC_MODE: prdata[0] = codec_mode_r;
      REG_CHECK_ONLY: prdata[0] = check_only_r;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= 1'b0;
      check_only_r <= 1'b0;
    end else if (cfg_wr) begin
      if (reg_idx_t'(paddr[2]) == REG_CODEC_MODE) codec_mode_r <= pwdata[0];
      if (reg_idx_t'(paddr[2]) == REG_CHECK_ONLY) check_only_r <= pwdata[0];
    end
  end

  // input register
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     fire;
  logic     res_free;

  assign res_free = !out_valid || !out_stall;
  assign fire     = s1_valid_r && res_free;
  assign in_stall = s1_valid_r && !res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_item_r <= in_item;
  end

  // scan state
  logic [31:0]         shift_r, shift_nxt, sw;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] zr_r, zr_nxt, zr_cand;
  logic                sps_r, sps_nxt;
  logic                pps_r, pps_nxt;
  logic                seq_r, seq_nxt;
  logic                decided_r, decided_nxt;
  logic                hit, emit;
  out_item_t           res_nxt;
  logic [31:0]         t, zr_ext, p_ext, mp_ofs;

  assign sw     = {shift_r[23:0], s1_item_r.data_byte};
  assign t      = sw & NAL_TYPE_MASK;
  assign zr_cand = (s1_item_r.data_byte == 8'h00 && shift_r[7:0] != 8'h00) ? pos_r : zr_r;
  assign zr_ext = 32'(zr_cand);
  assign p_ext  = 32'(pos_r);
  assign mp_ofs = (p_ext >= 32'd3) ? p_ext - 32'd3 : 32'd0;

  always_comb begin
    shift_nxt   = shift_r;
    pos_nxt     = pos_r;
    zr_nxt      = zr_r;
    sps_nxt     = sps_r;
    pps_nxt     = pps_r;
    seq_nxt     = seq_r;
    decided_nxt = decided_r;
    hit         = 1'b0;
    res_nxt     = '0;
    if (!decided_r) begin
      shift_nxt = sw;
      zr_nxt    = zr_cand;
      if (pos_r != POS_MAX) pos_nxt = pos_r + 1'b1;
      if (codec_mode_t'(codec_mode_r) == MODE_H264) begin
        if (t == NAL_SPS) begin
          sps_nxt = 1'b1;
        end else if (t == NAL_PPS) begin
          pps_nxt = 1'b1;
          if (check_only_r) begin
            hit                = 1'b1;
            res_nxt.compatible = sps_r;
          end
        end else if ((sw & PREFIX_MASK) == START_PREFIX && pps_r &&
                     (t == NAL_SLICE || t == NAL_SLICE_DPA || t == NAL_IDR)) begin
          hit                  = 1'b1;
          res_nxt.split_found  = 1'b1;
          res_nxt.split_offset = (zr_ext > OFS_MAX) ? 16'hFFFF : zr_ext[15:0];
        end
      end else begin
        if (sw == SEQ_HEADER) begin
          seq_nxt = 1'b1;
        end else if (seq_r && sw != SEQ_EXTENSION && sw >= START_PREFIX &&
                     sw < START_END) begin
          hit                  = 1'b1;
          res_nxt.split_found  = 1'b1;
          res_nxt.split_offset = (mp_ofs > OFS_MAX) ? 16'hFFFF : mp_ofs[15:0];
        end
      end
      if (hit || s1_item_r.last_byte) decided_nxt = 1'b1;
    end
    if (s1_item_r.last_byte) begin
      shift_nxt   = SHIFT_RESET;
      pos_nxt     = '0;
      zr_nxt      = '0;
      sps_nxt     = 1'b0;
      pps_nxt     = 1'b0;
      seq_nxt     = 1'b0;
      decided_nxt = 1'b0;
    end
  end

  assign emit = !decided_r && (hit || s1_item_r.last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= SHIFT_RESET;
      pos_r     <= '0;
      zr_r      <= '0;
      sps_r     <= 1'b0;
      pps_r     <= 1'b0;
      seq_r     <= 1'b0;
      decided_r <= 1'b0;
    end else if (fire) begin
      shift_r   <= shift_nxt;
      pos_r     <= pos_nxt;
      zr_r      <= zr_nxt;
      sps_r     <= sps_nxt;
      pps_r     <= pps_nxt;
      seq_r     <= seq_nxt;
      decided_r <= decided_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) out_item <= res_nxt;
  end

  // checks
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_item_r.last_byte |=> pos_r == '0 && !decided_r && shift_r == SHIFT_RESET)
    else $error("scan state not cleared after last byte");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && out_stall) |-> $past(fire && !decided_r))
    else $error("result appeared without a scanned byte");

  a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.split_found && out_item.compatible))
    else $error("split and compatibility reported together");

  a_no_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.split_found |-> out_item.split_offset == 16'h0000)
    else $error("offset nonzero without a split");

endmodule
